@@ sv/mck_pkg.sv @@
package mck_pkg;

	localparam int unsigned CODE_BITS = 12;
	localparam int unsigned LEN_BITS = 4;
	localparam int unsigned PC_BITS = 4;
	localparam logic [LEN_BITS-1:0] MAX_PATTERN_LENGTH = 4'd12;

	typedef logic [PC_BITS-1:0] pc_t;

	typedef enum logic [1:0] {
		CMD_CHAR    = 2'd0,
		CMD_PROSIGN = 2'd1,
		CMD_ELEMENT = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EL_DOT   = 2'd0,
		EL_DASH  = 2'd1,
		EL_LGAP  = 2'd2,
		EL_WGAP  = 2'd3
	} elem_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_CODE,
		KIND_WORD,
		KIND_LGAP,
		KIND_DOT,
		KIND_DASH
	} kind_t;

	typedef enum logic [1:0] {
		COND_FETCH,
		COND_DISPATCH,
		COND_LENZ,
		COND_NEXT
	} cond_t;

	typedef struct packed {
		logic                 emit;
		logic                 key_on;
		logic                 dash_sel;
		logic [2:0]           dur;
		logic                 last;
		logic                 dec;
		cond_t                cond;
		pc_t                  target;
	} uc_word_t;

	typedef struct packed {
		kind_t                kind;
		logic [LEN_BITS-1:0]  len;
		logic [CODE_BITS-1:0] bits;
	} dec_t;

	localparam logic [2:0] UNIT_DIT    = 3'd1;
	localparam logic [2:0] UNIT_DAH    = 3'd3;
	localparam logic [2:0] UNIT_LETTER = 3'd3;
	localparam logic [2:0] UNIT_WORD   = 3'd7;

	localparam pc_t PC_FETCH    = 4'd0;
	localparam pc_t PC_DISPATCH = 4'd1;
	localparam pc_t PC_WORD     = 4'd2;
	localparam pc_t PC_LGAP     = 4'd3;
	localparam pc_t PC_DOT      = 4'd4;
	localparam pc_t PC_DASH     = 4'd5;
	localparam pc_t PC_ELGAP    = 4'd6;
	localparam pc_t PC_MARK     = 4'd7;
	localparam pc_t PC_SPACE    = 4'd8;
	localparam pc_t PC_CGAP     = 4'd9;

	// Microcode: one control word per step.
	function automatic uc_word_t uc_rom(input pc_t pc);
		uc_word_t w;
		w = '{emit: 1'b0, key_on: 1'b0, dash_sel: 1'b0, dur: UNIT_DIT, last: 1'b0,
			dec: 1'b0, cond: COND_NEXT, target: PC_FETCH};
		unique case (pc)
			PC_FETCH: begin
				w.cond = COND_FETCH;
				w.target = PC_DISPATCH;
			end
			PC_DISPATCH: w.cond = COND_DISPATCH;
			PC_WORD: begin
				w.emit = 1'b1; w.dur = UNIT_WORD; w.last = 1'b1;
			end
			PC_LGAP: begin
				w.emit = 1'b1; w.dur = UNIT_LETTER; w.last = 1'b1;
			end
			PC_DOT: begin
				w.emit = 1'b1; w.key_on = 1'b1; w.dur = UNIT_DIT; w.target = PC_ELGAP;
			end
			PC_DASH: begin
				w.emit = 1'b1; w.key_on = 1'b1; w.dur = UNIT_DAH; w.target = PC_ELGAP;
			end
			PC_ELGAP: begin
				w.emit = 1'b1; w.dur = UNIT_DIT; w.last = 1'b1;
			end
			PC_MARK: begin
				w.emit = 1'b1; w.key_on = 1'b1; w.dash_sel = 1'b1;
				w.cond = COND_LENZ; w.target = PC_CGAP;
			end
			PC_SPACE: begin
				w.emit = 1'b1; w.dur = UNIT_DIT; w.dec = 1'b1; w.target = PC_MARK;
			end
			PC_CGAP: begin
				w.emit = 1'b1; w.dur = UNIT_LETTER; w.last = 1'b1;
			end
			default: w.target = PC_FETCH;
		endcase
		return w;
	endfunction

	function automatic pc_t dispatch_pc(input kind_t kind);
		pc_t pc;
		unique case (kind)
			KIND_CODE: pc = PC_MARK;
			KIND_WORD: pc = PC_WORD;
			KIND_LGAP: pc = PC_LGAP;
			KIND_DOT:  pc = PC_DOT;
			KIND_DASH: pc = PC_DASH;
			default:   pc = PC_FETCH;
		endcase
		return pc;
	endfunction

	// Code word: [15:12] element count, low bits elements, first in highest used bit.
	function automatic logic [15:0] letter_code(input logic [4:0] idx);
		logic [15:0] c;
		unique case (idx)
			5'd0:  c = 16'h2001; 5'd1:  c = 16'h4008; 5'd2:  c = 16'h400A;
			5'd3:  c = 16'h3004; 5'd4:  c = 16'h1000; 5'd5:  c = 16'h4002;
			5'd6:  c = 16'h3006; 5'd7:  c = 16'h4000; 5'd8:  c = 16'h2000;
			5'd9:  c = 16'h4007; 5'd10: c = 16'h3005; 5'd11: c = 16'h4004;
			5'd12: c = 16'h2003; 5'd13: c = 16'h2002; 5'd14: c = 16'h3007;
			5'd15: c = 16'h4006; 5'd16: c = 16'h400D; 5'd17: c = 16'h3002;
			5'd18: c = 16'h3000; 5'd19: c = 16'h1001; 5'd20: c = 16'h3001;
			5'd21: c = 16'h4001; 5'd22: c = 16'h3003; 5'd23: c = 16'h4009;
			5'd24: c = 16'h400B; 5'd25: c = 16'h400C;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

	function automatic logic [15:0] digit_code(input logic [3:0] idx);
		logic [15:0] c;
		unique case (idx)
			4'd0: c = 16'h501F; 4'd1: c = 16'h500F; 4'd2: c = 16'h5007;
			4'd3: c = 16'h5003; 4'd4: c = 16'h5001; 4'd5: c = 16'h5000;
			4'd6: c = 16'h5010; 4'd7: c = 16'h5018; 4'd8: c = 16'h501C;
			4'd9: c = 16'h501E;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

	// Returns {found, code}.
	function automatic logic [16:0] punct_code(input logic [7:0] ch);
		logic [16:0] r;
		unique case (ch)
			8'h21:   r = {1'b1, 16'h602B};
			8'h22:   r = {1'b1, 16'h6012};
			8'h24:   r = {1'b1, 16'h7009};
			8'h26:   r = {1'b1, 16'h5008};
			8'h28:   r = {1'b1, 16'h5016};
			8'h29:   r = {1'b1, 16'h602D};
			8'h2B:   r = {1'b1, 16'h500A};
			8'h2C:   r = {1'b1, 16'h6033};
			8'h2D:   r = {1'b1, 16'h6021};
			8'h2E:   r = {1'b1, 16'h6015};
			8'h2F:   r = {1'b1, 16'h5012};
			8'h3A:   r = {1'b1, 16'h6038};
			8'h3B:   r = {1'b1, 16'h602A};
			8'h3D:   r = {1'b1, 16'h5011};
			8'h3F:   r = {1'b1, 16'h600C};
			8'h40:   r = {1'b1, 16'h601A};
			8'h27:   r = {1'b1, 16'h601E};
			8'h5F:   r = {1'b1, 16'h600D};
			default: r = 17'h0_0000;
		endcase
		return r;
	endfunction

	function automatic logic [16:0] prosign_code(input logic [4:0] idx);
		logic [16:0] r;
		unique case (idx)
			5'd0:  r = {1'b1, 16'h5015}; 5'd1:  r = {1'b1, 16'h500A};
			5'd2:  r = {1'b1, 16'h6005}; 5'd3:  r = {1'b1, 16'h6005};
			5'd4:  r = {1'b1, 16'h6005}; 5'd5:  r = {1'b1, 16'h5008};
			5'd6:  r = {1'b1, 16'h6015}; 5'd7:  r = {1'b1, 16'h3005};
			5'd8:  r = {1'b1, 16'h3005}; 5'd9:  r = {1'b1, 16'h5002};
			5'd10: r = {1'b1, 16'h5002}; 5'd11: r = {1'b1, 16'h600C};
			5'd12: r = {1'b1, 16'h600C}; 5'd13: r = {1'b1, 16'h8000};
			5'd14: r = {1'b1, 16'h8000}; 5'd15: r = {1'b1, 16'h9038};
			5'd16: r = {1'b1, 16'h3002}; 5'd17: r = {1'b1, 16'h3002};
			5'd18: r = {1'b1, 16'h3005}; 5'd19: r = {1'b1, 16'h500A};
			5'd20: r = {1'b1, 16'h5008}; 5'd21: r = {1'b1, 16'h5002};
			5'd22: r = {1'b1, 16'h8000}; 5'd23: r = {1'b1, 16'h5011};
			5'd24: r = {1'b1, 16'h5015}; 5'd25: r = {1'b1, 16'h6005};
			5'd26: r = {1'b1, 16'h400A}; 5'd27: r = {1'b1, 16'h2002};
			default: r = 17'h0_0000;
		endcase
		return r;
	endfunction

	function automatic dec_t decode_request(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [4:0] ps, input logic [1:0] el);
		dec_t d;
		logic [7:0] uc;
		logic [7:0] ofs;
		logic [16:0] hit;
		d.kind = KIND_NONE;
		d.len = '0;
		d.bits = '0;
		hit = 17'h0_0000;
		uc = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
		ofs = 8'h00;
		unique case (cmd)
			CMD_CHAR: begin
				if (ch == 8'h20) begin
					d.kind = KIND_WORD;
				end else if (uc >= 8'h41 && uc <= 8'h5A) begin
					ofs = uc - 8'h41;
					hit = {1'b1, letter_code(ofs[4:0])};
				end else if (uc >= 8'h30 && uc <= 8'h39) begin
					ofs = uc - 8'h30;
					hit = {1'b1, digit_code(ofs[3:0])};
				end else begin
					hit = punct_code(uc);
				end
			end
			CMD_PROSIGN: hit = prosign_code(ps);
			CMD_ELEMENT: begin
				unique case (el)
					EL_DOT:  d.kind = KIND_DOT;
					EL_DASH: d.kind = KIND_DASH;
					EL_LGAP: d.kind = KIND_LGAP;
					EL_WGAP: d.kind = KIND_WORD;
					default: d.kind = KIND_NONE;
				endcase
			end
			default: d.kind = KIND_NONE;
		endcase
		// Drop patterns longer than the supported length.
		if (hit[16] && hit[15:12] <= MAX_PATTERN_LENGTH) begin
			d.kind = KIND_CODE;
			d.len = hit[15:12];
			d.bits = hit[11:0];
		end
		return d;
	endfunction

endpackage

@@ sv/morse_character_keyer_top.sv @@
// Morse character keyer. Each request on the s_ side (an ASCII character, a prosign
// number 0..27 or a raw element code, chosen by s_tuser) becomes a run of keying
// segments on the m_ side: key level in m_tdata[0], length in dit periods (1, 3 or 7)
// in m_tdata[3:1], and m_tlast on the final segment of the request. A dot is on 1 then
// off 1, a dash is on 3 then off 1, and a character or prosign closes with an extra off
// of 3; a blank gives a single off of 7. Lowercase is folded to uppercase. Unknown
// characters, prosigns 28 and up and command 3 produce no segment at all. One request
// is handled at a time by a small microcoded sequencer: a fetch step takes the request,
// a dispatch step picks the routine, and each further step emits at most one segment.
// A pattern runs fetch, dispatch, a mark and a space per element, one step that finds
// the count at zero, and the closing gap; the longest pattern has nine elements. A raw
// element runs fetch, dispatch and the steps for its segments, and a dropped request
// only fetch and dispatch. There is a single output register, and the program emits
// at most one segment per step.
// Backpressure on m_tready holds an emitting step until the output register has room.
module morse_character_keyer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // char_code[7:0], prosign_index[12:8], element_code[14:13]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // key_on[0], duration_units[3:1]
	output logic        m_tlast    // last_segment
);
	import mck_pkg::*;

	// Sequencer state
	pc_t                  pc_q;
	pc_t                  pc_next;
	kind_t                kind_q;
	logic [LEN_BITS-1:0]  cnt_q;
	logic [CODE_BITS-1:0] bits_q;

	// Output register
	logic                 m_valid_q;
	logic                 key_q;
	logic [2:0]           dur_q;
	logic                 last_q;

	uc_word_t             uc;
	dec_t                 dec;
	logic                 accept;
	logic                 can_emit;
	logic                 len_zero;
	logic                 seg_fire;
	logic                 stall;
	logic [3:0]           bit_idx;
	logic [2:0]           seg_dur;

	assign uc = uc_rom(pc_q);
	assign dec = decode_request(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[14:13]);

	assign s_tready = (uc.cond == COND_FETCH);
	assign accept   = s_tvalid && s_tready;

	// Output slot is free when empty or being drained this cycle.
	assign can_emit = !m_valid_q || m_tready;
	assign len_zero = (cnt_q == '0);

	// In the code loop a zero count skips the mark and jumps to the closing gap.
	assign seg_fire = uc.emit && can_emit && !((uc.cond == COND_LENZ) && len_zero);
	assign stall    = uc.emit && !can_emit;

	// Current element sits at bit (count - 1): first element in the highest used bit.
	assign bit_idx = cnt_q - 4'd1;
	assign seg_dur = uc.dash_sel ? (bits_q[bit_idx] ? UNIT_DAH : UNIT_DIT) : uc.dur;

	// Next step
	always_comb begin
		pc_next = pc_q;
		unique case (uc.cond)
			COND_FETCH: begin
				if (s_tvalid) begin
					pc_next = uc.target;
				end
			end
			COND_DISPATCH: pc_next = dispatch_pc(kind_q);
			COND_LENZ: begin
				if (len_zero) begin
					pc_next = uc.target;
				end else if (!stall) begin
					pc_next = pc_q + 4'd1;
				end
			end
			COND_NEXT: begin
				if (!stall) begin
					pc_next = uc.target;
				end
			end
			default: pc_next = PC_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

	// Request registers: load on accept, count elements down in the code loop.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= dec.kind;
			cnt_q  <= dec.len;
			bits_q <= dec.bits;
		end else if (seg_fire && uc.dec) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// Hold a segment until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (seg_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_fire) begin
			key_q  <= uc.key_on;
			dur_q  <= seg_dur;
			last_q <= uc.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, dur_q, key_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q == PC_DISPATCH)
		else $error("accepted request not followed by dispatch");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_fire && uc.last) |=> pc_q == PC_FETCH)
		else $error("last segment did not return to fetch");

	a_dur_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (dur_q == UNIT_DIT || dur_q == UNIT_DAH || dur_q == UNIT_WORD))
		else $error("illegal segment duration");

	a_mark_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && key_q) |-> !last_q)
		else $error("keyed segment marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_MARK || pc_q == PC_SPACE) |-> cnt_q <= MAX_PATTERN_LENGTH)
		else $error("element count out of range");
`endif

endmodule

@@ sim/tb_morse_character_keyer_top.sv @@
`timescale 1ns / 1ps

module tb_morse_character_keyer_top;
	import mck_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake on either side
	localparam int unsigned SETTLE_CYCLES = 32;  // lets a dropped request clear the sequencer

	typedef struct packed {
		logic       key_on;
		logic [2:0] units;
		logic       last;
	} segment_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // char_code[7:0], prosign_index[12:8], element_code[14:13]
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // key_on[0], duration_units[3:1]
	logic        m_tlast;   // last_segment

	// Code words: [15:12] element count, low bits the elements, first one in the
	// highest used bit, 1 = dash.
	logic [15:0] letter_morse [26] = '{
		16'h2001, 16'h4008, 16'h400A, 16'h3004, 16'h1000, 16'h4002, 16'h3006,
		16'h4000, 16'h2000, 16'h4007, 16'h3005, 16'h4004, 16'h2003, 16'h2002,
		16'h3007, 16'h4006, 16'h400D, 16'h3002, 16'h3000, 16'h1001, 16'h3001,
		16'h4001, 16'h3003, 16'h4009, 16'h400B, 16'h400C
	};
	logic [15:0] digit_morse [10] = '{
		16'h501F, 16'h500F, 16'h5007, 16'h5003, 16'h5001,
		16'h5000, 16'h5010, 16'h5018, 16'h501C, 16'h501E
	};
	logic [7:0] punct_glyph [18] = '{
		8'h21, 8'h22, 8'h24, 8'h26, 8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2D,
		8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h27, 8'h5F
	};
	logic [15:0] punct_morse [18] = '{
		16'h602B, 16'h6012, 16'h7009, 16'h5008, 16'h5016, 16'h602D, 16'h500A,
		16'h6033, 16'h6021, 16'h6015, 16'h5012, 16'h6038, 16'h602A, 16'h5011,
		16'h600C, 16'h601A, 16'h601E, 16'h600D
	};
	logic [15:0] prosign_morse [28] = '{
		16'h5015, 16'h500A, 16'h6005, 16'h6005, 16'h6005, 16'h5008, 16'h6015,
		16'h3005, 16'h3005, 16'h5002, 16'h5002, 16'h600C, 16'h600C, 16'h8000,
		16'h8000, 16'h9038, 16'h3002, 16'h3002, 16'h3005, 16'h500A, 16'h5008,
		16'h5002, 16'h8000, 16'h5011, 16'h5015, 16'h6005, 16'h400A, 16'h2002
	};

	segment_t segments_due [$];  // expected keying segments, oldest first
	int       mismatches;
	int       idle_cycles;
	bit       calm;              // no idling on either side once set
	int       stall_left;

	morse_character_keyer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the segments one accepted request must produce and queue them.
	task automatic predict_keying(input cmd_t cmd, input logic [7:0] ch,
			input logic [4:0] ps, input logic [1:0] el);
		segment_t run [$];
		logic [15:0] code;
		logic        have_code;
		logic [7:0]  up;
		int          len;
		have_code = 1'b0;
		code = '0;
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		case (cmd)
			CMD_CHAR: begin
				if (ch == " ") begin
					run.push_back('{1'b0, UNIT_WORD, 1'b0});
				end else if (up >= "A" && up <= "Z") begin
					code = letter_morse[up - "A"];
					have_code = 1'b1;
				end else if (up >= "0" && up <= "9") begin
					code = digit_morse[up - "0"];
					have_code = 1'b1;
				end else begin
					for (int i = 0; i < 18; i++)
						if (punct_glyph[i] == up) begin
							code = punct_morse[i];
							have_code = 1'b1;
						end
				end
			end
			CMD_PROSIGN: begin
				if (ps < 5'd28) begin
					code = prosign_morse[ps];
					have_code = 1'b1;
				end
			end
			CMD_ELEMENT: begin
				case (elem_t'(el))
					EL_DOT: begin
						run.push_back('{1'b1, UNIT_DIT, 1'b0});
						run.push_back('{1'b0, UNIT_DIT, 1'b0});
					end
					EL_DASH: begin
						run.push_back('{1'b1, UNIT_DAH, 1'b0});
						run.push_back('{1'b0, UNIT_DIT, 1'b0});
					end
					EL_LGAP: run.push_back('{1'b0, UNIT_LETTER, 1'b0});
					default: run.push_back('{1'b0, UNIT_WORD, 1'b0});
				endcase
			end
			default: ;
		endcase
		// Walk the pattern from its first element down; drop it if too long.
		if (have_code && code[15:12] <= MAX_PATTERN_LENGTH) begin
			len = code[15:12];
			for (int i = len; i > 0; i--) begin
				run.push_back('{1'b1, code[i-1] ? UNIT_DAH : UNIT_DIT, 1'b0});
				run.push_back('{1'b0, UNIT_DIT, 1'b0});
			end
			run.push_back('{1'b0, UNIT_LETTER, 1'b0});
		end
		if (run.size() > 0)
			run[run.size()-1].last = 1'b1;
		foreach (run[i])
			segments_due.push_back(run[i]);
	endtask

	// Present one request and hold it until the block takes it.
	task automatic send_request(input cmd_t cmd, input logic [7:0] ch,
			input logic [4:0] ps, input logic [1:0] el);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, el, ps, ch};
		do
			@(posedge clk);
		while (!s_tready);
		predict_keying(cmd, ch, ps, el);
	endtask

	// Drop valid for a random burst now and then.
	task automatic hold_off();
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 12);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (segments_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_supported_char();
		case ($urandom_range(0, 4))
			0:       return 8'("A" + $urandom_range(0, 25));
			1:       return 8'("a" + $urandom_range(0, 25));
			2:       return 8'("0" + $urandom_range(0, 9));
			3:       return " ";
			default: return punct_glyph[$urandom_range(0, 17)];
		endcase
	endfunction

	// Mostly well-formed requests with random content, plus junk that must drop.
	task automatic send_random_request();
		int         roll;
		cmd_t       cmd;
		logic [7:0] ch;
		logic [4:0] ps;
		logic [1:0] el;
		roll = $urandom_range(0, 19);
		ch = 8'($urandom);
		ps = 5'($urandom);
		el = 2'($urandom);
		if (roll < 10) begin
			cmd = CMD_CHAR;
			ch = pick_supported_char();
		end else if (roll < 12) begin
			cmd = CMD_CHAR;
		end else if (roll < 15) begin
			cmd = CMD_PROSIGN;
		end else if (roll < 18) begin
			cmd = CMD_ELEMENT;
		end else if (roll < 19) begin
			cmd = CMD_UNUSED;
		end else begin
			cmd = CMD_CHAR;
			ch = ch | 8'h80;
		end
		send_request(cmd, ch, ps, el);
	endtask

	// Field extremes, every command, and the dropped cases.
	task automatic test_directed();
		logic [7:0] chars [12] = '{" ", "A", "z", "0", "9", "$", "_", 8'h27,
			8'h00, 8'hFF, 8'h80, "#"};
		logic [4:0] signs [5] = '{5'd0, 5'd15, 5'd27, 5'd28, 5'd31};
		foreach (chars[i]) begin
			send_request(CMD_CHAR, chars[i], 5'($urandom), 2'($urandom));
			hold_off();
		end
		foreach (signs[i]) begin
			send_request(CMD_PROSIGN, 8'($urandom), signs[i], 2'($urandom));
			hold_off();
		end
		send_request(CMD_ELEMENT, 8'($urandom), 5'($urandom), EL_DOT);
		send_request(CMD_ELEMENT, 8'($urandom), 5'($urandom), EL_DASH);
		send_request(CMD_ELEMENT, 8'($urandom), 5'($urandom), EL_LGAP);
		send_request(CMD_ELEMENT, 8'($urandom), 5'($urandom), EL_WGAP);
		send_request(CMD_UNUSED, 8'h41, 5'd0, EL_DOT);
		hold_off();
	endtask

	task automatic test_random_stream(input int count);
		repeat (count) begin
			send_random_request();
			hold_off();
		end
	endtask

	// Let the output run dry, then pick up again from an idle block.
	task automatic test_pause_until_idle();
		test_random_stream(10);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		test_random_stream(10);
	endtask

	// Back-to-back requests with an always-ready sink.
	task automatic test_full_rate();
		calm = 1'b1;
		test_random_stream(50);
	endtask

	// Hold the sink ready except for random stall bursts.
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare every accepted segment with the oldest expected one.
	always @(posedge clk) begin
		segment_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (segments_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected segment: key_on=%0d units=%0d last=%0d",
						m_tdata[0], m_tdata[3:1], m_tlast);
			end else begin
				want = segments_due.pop_front();
				if (m_tdata[0] !== want.key_on || m_tdata[3:1] !== want.units ||
						m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("segment mismatch: expected key_on=%0d units=%0d last=%0d, got key_on=%0d units=%0d last=%0d",
							want.key_on, want.units, want.last,
							m_tdata[0], m_tdata[3:1], m_tlast);
				end
			end
		end
	end

	// Abort if neither side moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[morse_character_keyer_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_CHAR;
		mismatches = 0;
		idle_cycles = 0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_stream(80);
		test_pause_until_idle();
		test_random_stream(80);
		test_full_rate();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		if (mismatches == 0 && segments_due.size() == 0) begin
			$display("[morse_character_keyer_top] OK");
		end else begin
			$display("[morse_character_keyer_top] ERROR");
		end
		$finish;
	end

endmodule
